[design/gpad_pkg.sv]
package gpad_pkg;

  localparam int unsigned NUM_AXES  = 4;
  localparam int unsigned AXIS_W    = $clog2(NUM_AXES);
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [7:0]        SCRAMBLE_KEY = 8'h17;
  localparam logic [7:0]        ALL_ONES     = 8'hFF;
  localparam logic [7:0]        CENTER       = 8'd128;
  localparam logic signed [7:0] CAL_MAX_INIT = 8'sd100;
  localparam logic signed [7:0] CAL_MIN_INIT = -8'sd100;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
  } in_t;

  typedef struct packed {
    logic [7:0]  axis_x;
    logic [7:0]  axis_y;
    logic [7:0]  axis_rx;
    logic [7:0]  axis_ry;
    logic [7:0]  trigger_left;
    logic [7:0]  trigger_right;
    logic [14:0] buttons;
    logic        all_ones_fault;
  } out_t;

  typedef struct packed {
    logic              load_in;
    logic              setup;
    logic              step;
    logic              write;
    logic              publish;
    logic              cal_reset;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic fault;
  } sts_t;

endpackage

[design/gamepad_report_autocal_decoder_top.sv]
// Sequence: one setup, eight divide steps and one write per stick axis, then the output
// register load.
// The single shared 8-step restoring divider serves the four axes in turn; a new packet
// is taken only once the last is through, and may be taken while the last report waits.
// Reset: synchronous, active high; clears control and returns all stick calibration
// extremes to +100 / -100.
module gamepad_report_autocal_decoder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gpad_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gpad_pkg::out_t out_data
);

  gpad_pkg::cmd_t cmd;
  gpad_pkg::sts_t sts;

  gpad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gpad_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data),
    .sts      (sts)
  );

  // busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second beat while busy");

  // a report is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("report overwritten before it was taken");

  // datapath works only while a packet is in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.setup || cmd.step || cmd.write || cmd.publish))
    else $error("datapath command issued while idle");

endmodule

[design/gpad_dp.sv]
module gpad_dp (
  input  logic           clk,
  input  logic           rst,
  input  gpad_pkg::cmd_t cmd,
  input  gpad_pkg::in_t  in_data,
  output gpad_pkg::out_t out_data,
  output gpad_pkg::sts_t sts
);

  logic [7:0]        r [6];
  logic signed [7:0] cal_hi [gpad_pkg::NUM_AXES];
  logic signed [7:0] cal_lo [gpad_pkg::NUM_AXES];
  logic [7:0]        ax [gpad_pkg::NUM_AXES];

  logic [7:0] rem;
  logic [7:0] quo;
  logic [7:0] den;
  logic       pos;

  logic signed [7:0] v;
  logic signed [7:0] hi_new;
  logic signed [7:0] lo_new;
  logic              v_pos;
  logic [7:0]        mag;
  logic [7:0]        lo_mag;
  logic [14:0]       num;
  logic [7:0]        den_new;
  logic [8:0]        trial;
  logic [8:0]        diff;
  logic              ge;
  logic [7:0]        n4;
  logic [7:0]        n5;
  logic [14:0]       btn;

  // raw axes; "k - 128" is an MSB flip, "127 - u" is the complement with MSB flipped
  always_comb begin
    case (cmd.axis)
      2'd0:    v = {~r[0][5], r[0][4:0], 2'b00};
      2'd1:    v = {r[1][5], ~r[1][4:0], 2'b11};
      2'd2:    v = {~r[0][7], r[0][6], r[1][7:6], r[2][7], 3'b000};
      default: v = {r[2][4], ~r[2][3:0], 3'b111};
    endcase
  end

  assign hi_new  = (v > cal_hi[cmd.axis]) ? v : cal_hi[cmd.axis];
  assign lo_new  = (v < cal_lo[cmd.axis]) ? v : cal_lo[cmd.axis];
  assign v_pos   = !v[7] && (v != 8'sd0);
  assign mag     = 8'(-v);
  assign lo_mag  = 8'(-lo_new);
  // positive: v*127 = (v << 7) - v; otherwise ceiling numerator -v*128 + (-min) - 1
  assign num     = v_pos ? ({1'b0, v[6:0], 7'b0} - {8'b0, v[6:0]})
                         : ({mag, 7'b0} + {7'b0, lo_mag} - 15'd1);
  assign den_new = v_pos ? {1'b0, hi_new[6:0]} : lo_mag;

  assign trial = {rem, quo[7]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  assign sts.fault = (r[0] == gpad_pkg::ALL_ONES) && (r[1] == gpad_pkg::ALL_ONES) &&
                     (r[2] == gpad_pkg::ALL_ONES) && (r[3] == gpad_pkg::ALL_ONES) &&
                     (r[4] == gpad_pkg::ALL_ONES) && (r[5] == gpad_pkg::ALL_ONES);

  assign n4 = ~r[4];
  assign n5 = ~r[5];
  assign btn = {n4[7], n5[1], n4[6], n5[0], n5[7], n5[2], n4[5], n4[1],
                n4[3], n4[4], n4[2], n5[5], n5[6], n5[4], n5[3]};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r[0] <= (in_data.byte0 ^ gpad_pkg::SCRAMBLE_KEY) + gpad_pkg::SCRAMBLE_KEY;
      r[1] <= (in_data.byte1 ^ gpad_pkg::SCRAMBLE_KEY) + gpad_pkg::SCRAMBLE_KEY;
      r[2] <= (in_data.byte2 ^ gpad_pkg::SCRAMBLE_KEY) + gpad_pkg::SCRAMBLE_KEY;
      r[3] <= (in_data.byte3 ^ gpad_pkg::SCRAMBLE_KEY) + gpad_pkg::SCRAMBLE_KEY;
      r[4] <= (in_data.byte4 ^ gpad_pkg::SCRAMBLE_KEY) + gpad_pkg::SCRAMBLE_KEY;
      r[5] <= (in_data.byte5 ^ gpad_pkg::SCRAMBLE_KEY) + gpad_pkg::SCRAMBLE_KEY;
    end
    // quotient is below 256, so the top seven numerator bits seed the remainder
    if (cmd.setup) begin
      rem <= {1'b0, num[14:8]};
      quo <= num[7:0];
      den <= den_new;
      pos <= v_pos;
    end else if (cmd.step) begin
      rem <= ge ? diff[7:0] : trial[7:0];
      quo <= {quo[6:0], ge};
    end
    if (cmd.write) begin
      ax[cmd.axis] <= pos ? (gpad_pkg::CENTER + quo) : (gpad_pkg::CENTER - quo);
    end
    if (cmd.publish) begin
      out_data.axis_x         <= ax[0];
      out_data.axis_y         <= ax[1];
      out_data.axis_rx        <= ax[2];
      out_data.axis_ry        <= ax[3];
      out_data.trigger_left   <= {r[2][6:5], r[3][7:5], 3'b000};
      out_data.trigger_right  <= {r[3][4:0], 3'b000};
      out_data.buttons        <= btn;
      out_data.all_ones_fault <= sts.fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.cal_reset) begin
      for (int i = 0; i < gpad_pkg::NUM_AXES; i++) begin
        cal_hi[i] <= gpad_pkg::CAL_MAX_INIT;
        cal_lo[i] <= gpad_pkg::CAL_MIN_INIT;
      end
    end else if (cmd.setup) begin
      cal_hi[cmd.axis] <= hi_new;
      cal_lo[cmd.axis] <= lo_new;
    end
  end

endmodule

[design/gpad_ctrl.sv]
module gpad_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  gpad_pkg::sts_t sts,
  output gpad_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SETUP,
    DIVIDE,
    WRITE,
    FINISH
  } state_t;

  state_t                      state;
  logic [gpad_pkg::AXIS_W-1:0] axis;
  logic [gpad_pkg::STEP_W-1:0] step;
  logic                        publish;

  assign in_ready = (state == IDLE);
  assign publish  = (state == FINISH) && (!out_valid || out_ready);

  assign cmd.load_in   = in_valid && in_ready;
  assign cmd.setup     = (state == SETUP);
  assign cmd.step      = (state == DIVIDE);
  assign cmd.write     = (state == WRITE);
  assign cmd.publish   = publish;
  assign cmd.cal_reset = publish && sts.fault;
  assign cmd.axis      = axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      axis      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            axis  <= '0;
            state <= SETUP;
          end
        end
        SETUP: begin
          step  <= '0;
          state <= DIVIDE;
        end
        DIVIDE: begin
          step <= step + 1'b1;
          if (step == gpad_pkg::STEP_W'(gpad_pkg::DIV_STEPS - 1)) begin
            state <= WRITE;
          end
        end
        WRITE: begin
          if (axis == gpad_pkg::AXIS_W'(gpad_pkg::NUM_AXES - 1)) begin
            state <= FINISH;
          end else begin
            axis  <= axis + 1'b1;
            state <= SETUP;
          end
        end
        FINISH: begin
          if (publish) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[verif/tb_gamepad_report_autocal_decoder_top.sv]
`timescale 1ns / 1ps
module tb_gamepad_report_autocal_decoder_top;

  localparam int NUM_RANDOM = 1950;
  localparam int MAX_WAIT   = 18;
  localparam int DRAIN_WAIT = 60;

  // Reports fixed by the extremes alone, whatever the calibration holds.
  localparam gpad_pkg::out_t ZERO_PKT_REPORT =
    '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 15'h7FFF, 1'b0};
  localparam gpad_pkg::out_t ONES_PKT_REPORT =
    '{8'd255, 8'd0, 8'd255, 8'd0, 8'd248, 8'd248, 15'h0, 1'b1};

  typedef struct {
    logic [47:0]    plain;   // descrambled bytes r0..r5
    bit             typed;
    gpad_pkg::out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  gpad_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gpad_pkg::out_t out_data;

  logic signed [7:0] stick_hi [gpad_pkg::NUM_AXES];
  logic signed [7:0] stick_lo [gpad_pkg::NUM_AXES];
  gpad_pkg::out_t report_q [$];
  int   errors = 0;
  int   packets_sent = 0;
  int   faults_sent = 0;
  int   reports_seen = 0;

  dir_row_t dir_rows [18] = '{
    '{48'h00_00_00_00_00_00, 1'b1, ZERO_PKT_REPORT},
    '{48'hFF_FF_FF_FF_FF_FF, 1'b1, ONES_PKT_REPORT},
    '{48'h39_20_10_00_FF_FF, 1'b0, '0},  // x = +100, calibration must be back to reset
    '{48'hA0_20_10_00_FF_FF, 1'b0, '0},  // all sticks near center
    '{48'hA1_1F_10_00_FF_FF, 1'b0, '0},
    '{48'h9F_21_0F_00_FF_FF, 1'b0, '0},
    '{48'h3F_3F_9F_00_FF_FF, 1'b0, '0},  // x max, y min, ry min
    '{48'hC0_C0_80_00_FF_FF, 1'b0, '0},  // x min, y max, rx max, ry max
    '{48'h20_20_60_E0_FF_FF, 1'b0, '0},  // left trigger full
    '{48'h20_20_00_1F_FF_FF, 1'b0, '0},  // right trigger full
    '{48'h20_20_10_00_00_FF, 1'b0, '0},  // every byte4 button pressed
    '{48'h20_20_10_00_FF_00, 1'b0, '0},  // every byte5 button pressed
    '{48'h20_20_10_00_55_AA, 1'b0, '0},
    '{48'h20_20_10_00_AA_55, 1'b0, '0},
    '{48'hFF_FF_FF_FF_FF_FE, 1'b0, '0},  // one bit short of a fault
    '{48'h7F_FF_FF_FF_FF_FF, 1'b0, '0},
    '{48'hFF_FF_FF_FF_FF_FF, 1'b1, ONES_PKT_REPORT},
    '{48'h21_1F_11_00_FF_FF, 1'b0, '0}   // small values right after restore
  };

  always #4 clk = ~clk;

  gamepad_report_autocal_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic void restore_cal();
    for (int a = 0; a < gpad_pkg::NUM_AXES; a++) begin
      stick_hi[a] = gpad_pkg::CAL_MAX_INIT;
      stick_lo[a] = gpad_pkg::CAL_MIN_INIT;
    end
  endfunction

  // Widen the extremes of one stick by v, then map v onto 0..255 around 128.
  function automatic logic [7:0] scale_stick(int v, int ax);
    int hi;
    int lo;
    int q;
    if (v > stick_hi[ax]) stick_hi[ax] = 8'(v);
    if (v < stick_lo[ax]) stick_lo[ax] = 8'(v);
    hi = stick_hi[ax];
    lo = stick_lo[ax];
    if (v > 0) q = 128 + (v * 127) / hi;
    else q = 128 - ((-v) * 128 - lo - 1) / (-lo);
    return q[7:0];
  endfunction

  function automatic gpad_pkg::out_t predict_report(gpad_pkg::in_t p);
    logic [47:0]    flat;
    logic [7:0]     r [6];
    logic [7:0]     n4;
    logic [7:0]     n5;
    bit             ones;
    int             x;
    int             y;
    int             rx;
    int             ry;
    gpad_pkg::out_t rep;
    flat = p;
    ones = 1'b1;
    for (int i = 0; i < 6; i++) begin
      r[i] = (flat[47-8*i -: 8] ^ gpad_pkg::SCRAMBLE_KEY) + gpad_pkg::SCRAMBLE_KEY;
      if (r[i] != gpad_pkg::ALL_ONES) ones = 1'b0;
    end
    x  = int'({r[0][5:0], 2'b00}) - 128;
    y  = 127 - int'({r[1][5:0], 2'b00});
    rx = int'({r[0][7:6], r[1][7:6], r[2][7], 3'b000}) - 128;
    ry = 127 - int'({r[2][4:0], 3'b000});
    rep.axis_x  = scale_stick(x, 0);
    rep.axis_y  = scale_stick(y, 1);
    rep.axis_rx = scale_stick(rx, 2);
    rep.axis_ry = scale_stick(ry, 3);
    rep.trigger_left  = {r[2][6:5], r[3][7:5], 3'b000};
    rep.trigger_right = {r[3][4:0], 3'b000};
    n4 = ~r[4];
    n5 = ~r[5];
    rep.buttons = {n4[7], n5[1], n4[6], n5[0], n5[7], n5[2], n4[5], n4[1],
                   n4[3], n4[4], n4[2], n5[5], n5[6], n5[4], n5[3]};
    rep.all_ones_fault = ones;
    if (ones) restore_cal();
    return rep;
  endfunction

  function automatic gpad_pkg::in_t scramble_packet(logic [47:0] plain);
    logic [47:0] flat;
    for (int i = 0; i < 6; i++)
      flat[47-8*i -: 8] = (plain[47-8*i -: 8] - gpad_pkg::SCRAMBLE_KEY) ^
                          gpad_pkg::SCRAMBLE_KEY;
    return flat;
  endfunction

  // Mostly sticks that widen the calibration a little at a time, with faults
  // often enough that the extremes keep starting over.
  function automatic logic [47:0] random_plain();
    logic [7:0]  r [6];
    logic [4:0]  rx5;
    logic [47:0] plain;
    int          mode;
    for (int i = 0; i < 6; i++) r[i] = 8'($urandom);
    mode = $urandom_range(0, 99);
    if (mode < 5) return '1;
    if (mode < 9) begin
      plain = '1;
      plain[$urandom_range(0, 47)] = 1'b0;
      return plain;
    end
    if (mode < 88) begin
      r[0][5:0] = 6'($urandom_range(4, 60));
      r[1][5:0] = 6'($urandom_range(4, 60));
      rx5 = 5'($urandom_range(2, 30));
      r[0][7:6] = rx5[4:3];
      r[1][7:6] = rx5[2:1];
      r[2][7]   = rx5[0];
      r[2][4:0] = 5'($urandom_range(1, 30));
    end
    return {r[0], r[1], r[2], r[3], r[4], r[5]};
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_packet(gpad_pkg::in_t p, bit typed, gpad_pkg::out_t want, int gap);
    gpad_pkg::out_t exp_rep;
    exp_rep = predict_report(p);
    if (typed) exp_rep = want;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    report_q.push_back(exp_rep);
    packets_sent++;
    faults_sent += exp_rep.all_ones_fault;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_report(gpad_pkg::out_t got);
    gpad_pkg::out_t want;
    if (report_q.size() == 0) begin
      $error("report beat with no packet outstanding");
      errors++;
      return;
    end
    want = report_q.pop_front();
    check_field("axis_x", got.axis_x, want.axis_x);
    check_field("axis_y", got.axis_y, want.axis_y);
    check_field("axis_rx", got.axis_rx, want.axis_rx);
    check_field("axis_ry", got.axis_ry, want.axis_ry);
    check_field("trigger_left", got.trigger_left, want.trigger_left);
    check_field("trigger_right", got.trigger_right, want.trigger_right);
    check_field("buttons", got.buttons, want.buttons);
    check_field("all_ones_fault", got.all_ones_fault, want.all_ones_fault);
  endtask

  // Report side: random stalls, with calm stretches where ready stays high.
  initial begin
    bit calm;
    int stall;
    calm = 1'b0;
    forever begin
      if (reports_seen % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = draw_wait(calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_report(out_data);
      reports_seen++;
    end
  end

  initial begin
    bit calm;
    restore_cal();
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_packet(scramble_packet(dir_rows[i].plain), dir_rows[i].typed, dir_rows[i].want,
                  draw_wait(1'b0));
    wait_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == NUM_RANDOM / 2) wait_drained();
      send_packet(scramble_packet(random_plain()), 1'b0, '0, draw_wait(calm));
    end
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d packets (%0d all-ones faults), checked %0d reports;",
             packets_sent, faults_sent, reports_seen);
    $display("sticks swept across fresh and widened calibration, all buttons and triggers.");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d reports still outstanding", report_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
